// ===== src/tvg_pkg.sv =====
// ----------------------------------------------------------------------------
// tvg_pkg
// Shared types, command codes and CORDIC constants for the turtle vector
// generator.
// ----------------------------------------------------------------------------
package tvg_pkg;

    // Command codes on the operation field
    typedef enum logic [2:0] {
        OP_SET_POSE = 3'd0,
        OP_FORWARD  = 3'd1,
        OP_BACKWARD = 3'd2,
        OP_RIGHT    = 3'd3,
        OP_LEFT     = 3'd4,
        OP_PEN      = 3'd5,
        OP_RESET    = 3'd6
    } t_op;

    // Work handed from the front to the back
    typedef enum logic [1:0] {
        JOB_SETPOS = 2'd0,
        JOB_FWD    = 2'd1,
        JOB_BWD    = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [31:0] a;        // new x, or move distance
        logic [31:0] b;        // new y
        logic [15:0] heading;  // heading at the time of the move
        logic        pen;      // pen state at the time of the move
    } t_job;

    // One drawn line segment
    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] ex;
        logic [31:0] ey;
    } t_seg;

    // CORDIC gain compensation, 1/K scaled by 2^32
    localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

    // Quarter turn and half turn in binary angle units
    localparam logic [15:0] QUARTER_TURN = 16'd16384;
    localparam logic [15:0] HALF_TURN    = 16'd32768;

    // atan(2^-i) in units of 2^-32 of a turn
    function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:    v = 32'd536870912;
                5'd1:    v = 32'd316933406;
                5'd2:    v = 32'd167458907;
                5'd3:    v = 32'd85004756;
                5'd4:    v = 32'd42667331;
                5'd5:    v = 32'd21354465;
                5'd6:    v = 32'd10679838;
                5'd7:    v = 32'd5340245;
                5'd8:    v = 32'd2670163;
                5'd9:    v = 32'd1335087;
                5'd10:   v = 32'd667544;
                5'd11:   v = 32'd333772;
                5'd12:   v = 32'd166886;
                5'd13:   v = 32'd83443;
                5'd14:   v = 32'd41722;
                5'd15:   v = 32'd20861;
                5'd16:   v = 32'd10430;
                5'd17:   v = 32'd5215;
                5'd18:   v = 32'd2608;
                5'd19:   v = 32'd1304;
                5'd20:   v = 32'd652;
                5'd21:   v = 32'd326;
                5'd22:   v = 32'd163;
                5'd23:   v = 32'd81;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== src/tvg_fifo.sv =====
// ----------------------------------------------------------------------------
// tvg_fifo
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module tvg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push_en;
    logic             w_pop_en;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_push_en = i_push && !o_full;
    assign w_pop_en  = i_pop && !o_empty;
    assign o_rdata   = r_mem[r_rd];

    // Pointer and count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push_en) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop_en) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push_en && !w_pop_en) begin
            n_count = r_count + 1'b1;
        end else if (!w_push_en && w_pop_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push_en) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

// ===== src/tvg_front.sv =====
// ----------------------------------------------------------------------------
// tvg_front
// Command decoder: keeps heading and pen state, and forwards position work
// (set pose, moves, reset pose) to the back end as jobs.
// ----------------------------------------------------------------------------
module tvg_front import tvg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_new_x,
    input  logic [31:0] i_new_y,
    input  logic [15:0] i_angle,
    input  logic [31:0] i_distance,
    input  logic        i_pen_down,
    output t_job        o_job,
    output logic        o_job_push
);
    logic [15:0] r_heading, n_heading;
    logic        r_pen, n_pen;

    // Decode one item
    always_comb begin
        n_heading     = r_heading;
        n_pen         = r_pen;
        o_job_push    = 1'b0;
        o_job.kind    = JOB_SETPOS;
        o_job.a       = i_distance;
        o_job.b       = i_new_y;
        o_job.heading = r_heading;
        o_job.pen     = r_pen;
        case (t_op'(i_operation))
            OP_SET_POSE: begin
                o_job_push = i_accept;
                o_job.a    = i_new_x;
                n_heading  = i_angle;
            end
            OP_FORWARD: begin
                o_job_push = i_accept;
                o_job.kind = JOB_FWD;
            end
            OP_BACKWARD: begin
                o_job_push = i_accept;
                o_job.kind = JOB_BWD;
            end
            OP_RIGHT: begin
                n_heading = r_heading - i_angle;
            end
            OP_LEFT: begin
                n_heading = r_heading + i_angle;
            end
            OP_PEN: begin
                n_pen = i_pen_down;
            end
            OP_RESET: begin
                o_job_push = i_accept;
                o_job.a    = '0;
                o_job.b    = '0;
                n_heading  = '0;
            end
            default: begin
                // unused code: no effect
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
            r_pen     <= 1'b0;
        end else if (i_accept) begin
            r_heading <= n_heading;
            r_pen     <= n_pen;
        end
    end

endmodule

// ===== src/tvg_back.sv =====
// ----------------------------------------------------------------------------
// tvg_back
// Position engine: applies set-pose jobs, runs an iterative CORDIC rotation
// for moves, saturates the new position and emits segments with pen down.
// ----------------------------------------------------------------------------
module tvg_back import tvg_pkg::*; #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_job,
    input  logic i_job_valid,
    output logic o_job_pop,
    output t_seg o_seg,
    output logic o_seg_push,
    input  logic i_seg_full
);
    localparam int DW = 34 + FRAC_BITS;     // rotation datapath width
    localparam int ZW = 34;                 // angle accumulator width
    localparam int RW = 35;                 // rounded delta width
    localparam int NW = 37;                 // position sum width
    localparam int IW = $clog2(CORDIC_STAGES);
    localparam int PS = 32 - FRAC_BITS;     // product to datapath shift
    localparam logic signed [64:0] PROD_HALF = 65'sd1 <<< (PS - 1);
    localparam logic signed [DW:0] X_HALF    = (DW + 1)'(1) <<< (FRAC_BITS - 1);
    localparam logic [IW-1:0]      LAST_ITER = IW'(CORDIC_STAGES - 1);
    localparam logic signed [NW-1:0] POS_MAX = NW'(64'sd2147483647);
    localparam logic signed [NW-1:0] POS_MIN = NW'(-64'sd2147483648);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ROT,
        S_ROUND,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic signed [31:0] r_pos_x, n_pos_x;
    logic signed [31:0] r_pos_y, n_pos_y;

    logic signed [64:0]   r_prod;
    logic [15:0]          r_head;
    logic                 r_sub;
    logic                 r_pen;
    logic signed [DW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [IW-1:0]        r_iter;
    logic signed [RW-1:0] r_dx, r_dy;

    logic signed [64:0]   w_prod;
    logic signed [64:0]   w_prod_rnd;
    logic [15:0]          w_head_q;
    logic                 w_flip;
    logic [15:0]          w_head_rot;
    logic signed [DW-1:0] w_x0;
    logic signed [ZW-1:0] w_z0;
    logic signed [DW-1:0] w_xs, w_ys;
    logic signed [ZW-1:0] w_atan;
    logic signed [DW:0]   w_xr, w_yr;
    logic signed [DW:0]   w_dx_full, w_dy_full;
    logic signed [NW-1:0] w_nx, w_ny;
    logic signed [31:0]   w_nx_sat, w_ny_sat;
    logic                 w_done_go;

    function automatic logic signed [31:0] sat32(input logic signed [NW-1:0] v);
        logic signed [31:0] r;
        begin
            if (v > POS_MAX) begin
                r = 32'sh7FFF_FFFF;
            end else if (v < POS_MIN) begin
                r = 32'sh8000_0000;
            end else begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

    // Gain compensation product of the distance at the queue head
    assign w_prod = 65'($signed(i_job.a)) * 65'($signed({1'b0, GAIN_Q32}));

    // Pre-rotation: round product, fold heading into the right half-plane
    assign w_prod_rnd = (r_prod + PROD_HALF) >>> PS;
    assign w_x0       = w_prod_rnd[DW-1:0];
    assign w_head_q   = r_head + QUARTER_TURN;
    assign w_flip     = w_head_q[15];
    assign w_head_rot = w_flip ? (r_head + HALF_TURN) : r_head;
    assign w_z0       = {{2{w_head_rot[15]}}, w_head_rot, 16'h0000};

    // One rotation step
    assign w_xs   = r_x >>> r_iter;
    assign w_ys   = r_y >>> r_iter;
    assign w_atan = {2'b00, atan_turn32(5'(r_iter))};

    // Drop the extra fraction bits, half up
    assign w_xr      = (DW + 1)'(r_x) + X_HALF;
    assign w_yr      = (DW + 1)'(r_y) + X_HALF;
    assign w_dx_full = w_xr >>> FRAC_BITS;
    assign w_dy_full = w_yr >>> FRAC_BITS;

    // Position update with saturation
    assign w_nx     = r_sub ? (NW'(r_pos_x) - NW'(r_dx)) : (NW'(r_pos_x) + NW'(r_dx));
    assign w_ny     = r_sub ? (NW'(r_pos_y) - NW'(r_dy)) : (NW'(r_pos_y) + NW'(r_dy));
    assign w_nx_sat = sat32(w_nx);
    assign w_ny_sat = sat32(w_ny);

    assign w_done_go  = (r_state == S_DONE) && (!r_pen || !i_seg_full);
    assign o_job_pop  = (r_state == S_IDLE) && i_job_valid;
    assign o_seg_push = w_done_go && r_pen;
    assign o_seg      = '{sx: r_pos_x, sy: r_pos_y, ex: w_nx_sat, ey: w_ny_sat};

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    case (i_job.kind)
                        JOB_SETPOS: begin
                            n_pos_x = $signed(i_job.a);
                            n_pos_y = $signed(i_job.b);
                        end
                        JOB_FWD, JOB_BWD: begin
                            n_state = S_INIT;
                        end
                        default: begin
                            // unknown job: dropped
                        end
                    endcase
                end
            end
            S_INIT: begin
                n_state = S_ROT;
            end
            S_ROT: begin
                if (r_iter == LAST_ITER) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_done_go) begin
                    n_pos_x = w_nx_sat;
                    n_pos_y = w_ny_sat;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else begin
            r_state <= n_state;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
        end
    end

    // Rotation datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_prod <= w_prod;
                r_head <= i_job.heading;
                r_sub  <= (i_job.kind == JOB_BWD);
                r_pen  <= i_job.pen;
            end
            S_INIT: begin
                r_x    <= w_flip ? -w_x0 : w_x0;
                r_y    <= '0;
                r_z    <= w_z0;
                r_iter <= '0;
            end
            S_ROT: begin
                if (!r_z[ZW-1]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_atan;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_atan;
                end
                r_iter <= r_iter + 1'b1;
            end
            S_ROUND: begin
                r_dx <= w_dx_full[RW-1:0];
                r_dy <= w_dy_full[RW-1:0];
            end
            default: begin
                // hold
            end
        endcase
    end

endmodule

// ===== src/turtle_vector_generator_top.sv =====
// Turtle vector generator. Turns, pen and unused commands stay in the decoder.
// Set pose / reset pose: one item per cycle through the job queue while the
// position engine is idle. Move: the engine steps through its init, rotation,
// round and done states on the single shared shift-add rotation unit; a full
// segment queue can hold it in the done state before the segment is pushed.
// Synchronous active-low reset clears pose, pen state and both queues.
// ----------------------------------------------------------------------------
// turtle_vector_generator_top
// Front decoder, job queue, position engine and segment queue.
// ----------------------------------------------------------------------------
module turtle_vector_generator_top import tvg_pkg::*; #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_new_x,
    input  logic signed [31:0] i_new_y,
    input  logic [15:0]        i_angle,
    input  logic signed [31:0] i_distance,
    input  logic               i_pen_down,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_start_x,
    output logic signed [31:0] o_start_y,
    output logic signed [31:0] o_end_x,
    output logic signed [31:0] o_end_y
);
    localparam int JOB_DEPTH = 2;
    localparam int SEG_DEPTH = 2;

    logic w_accept;
    t_job w_job_in, w_job_head;
    logic w_job_push, w_job_full, w_job_empty, w_job_pop;
    logic [$bits(t_job)-1:0] w_job_rdata;
    t_seg w_seg_in, w_seg_out;
    logic w_seg_push, w_seg_full;
    logic [$bits(t_seg)-1:0] w_seg_rdata;

    assign full     = w_job_full;
    assign w_accept = push && !w_job_full;

    // Command decode
    tvg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_operation (i_operation),
        .i_new_x     (i_new_x),
        .i_new_y     (i_new_y),
        .i_angle     (i_angle),
        .i_distance  (i_distance),
        .i_pen_down  (i_pen_down),
        .o_job       (w_job_in),
        .o_job_push  (w_job_push)
    );

    // Queue between decode and position engine
    tvg_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_wdata (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_rdata (w_job_rdata),
        .o_empty (w_job_empty)
    );

    assign w_job_head = t_job'(w_job_rdata);

    // Position engine
    tvg_back #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job_head),
        .i_job_valid (!w_job_empty),
        .o_job_pop   (w_job_pop),
        .o_seg       (w_seg_in),
        .o_seg_push  (w_seg_push),
        .i_seg_full  (w_seg_full)
    );

    // Segment output queue
    tvg_fifo #(
        .WIDTH ($bits(t_seg)),
        .DEPTH (SEG_DEPTH)
    ) u_seg_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_seg_push),
        .i_wdata (w_seg_in),
        .o_full  (w_seg_full),
        .i_pop   (pop),
        .o_rdata (w_seg_rdata),
        .o_empty (empty)
    );

    assign w_seg_out = t_seg'(w_seg_rdata);
    assign o_start_x = $signed(w_seg_out.sx);
    assign o_start_y = $signed(w_seg_out.sy);
    assign o_end_x   = $signed(w_seg_out.ex);
    assign o_end_y   = $signed(w_seg_out.ey);

    // Decoder never pushes a job into a full queue
    a_job_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_push |-> !w_job_full)
        else $error("job pushed into full queue");

    // Engine never drops a segment on a full output queue
    a_seg_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seg_push |-> !w_seg_full)
        else $error("segment pushed into full queue");

    // Engine pops only a job that is present
    a_job_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |-> !w_job_empty)
        else $error("job popped from empty queue");

    // A segment push never directly follows a job pop
    a_seg_after_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seg_push |-> !$past(w_job_pop))
        else $error("segment without rotation");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Turtle vector generator testbench
// Sends turtle commands through the push/full side and pops line segments
// from the empty/pop side. A CORDIC pose tracker predicts every segment, and
// a scoreboard compares each popped segment with the oldest prediction.
// Runs directed corner cases first, then three random phases with different
// idle patterns, a long receiver hold-off and a full drain after phases 1 and 3.
// ----------------------------------------------------------------------------
module testbench;
    import tvg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 16;
    localparam int ATAN_LEN      = 24;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int TAIL_CYCLES   = 60;
    localparam int HOLD_CYCLES   = 2000;
    localparam int PHASE_ITEMS   = 617;

    // Code 7 is not a command; the block must ignore it
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // atan(2^-i), 2^-32 turn units
    localparam longint ATAN_TURN [0:ATAN_LEN-1] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // ------------------------------------------------------------------
    // Pose tracker and segment scoreboard
    // ------------------------------------------------------------------
    class segment_tracker;
        longint      pos_x;
        longint      pos_y;
        logic [15:0] heading;
        logic        pen;
        t_seg        expected_segments[$];
        int          errors;

        function new();
            pos_x   = 0;
            pos_y   = 0;
            heading = '0;
            pen     = 1'b0;
            errors  = 0;
        endfunction

        function longint round_shr(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // CORDIC rotation of the distance by the heading
        function void rotate_distance(longint dist_in, logic [15:0] hd,
                                      output longint dx, output longint dy);
            longint      x;
            longint      y;
            longint      z;
            longint      xs;
            longint      ys;
            logic [15:0] h;
            logic [15:0] q;
            x = round_shr(dist_in * longint'(GAIN_Q32), 32 - FRAC_BITS);
            y = 0;
            h = hd;
            q = h + QUARTER_TURN;
            // left half plane: flip the vector, turn by half a turn
            if (q[15]) begin
                x = -x;
                h = h + HALF_TURN;
            end
            z = longint'($signed(h)) * 65536;
            for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_TURN[i];
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_TURN[i];
                end
            end
            dx = round_shr(x, FRAC_BITS);
            dy = round_shr(y, FRAC_BITS);
        endfunction

        // Update the pose for one accepted item
        function void note_command(logic [2:0] op, logic signed [31:0] nx,
                                   logic signed [31:0] ny, logic [15:0] ang,
                                   logic signed [31:0] move_len, logic pen_bit);
            longint dx;
            longint dy;
            longint ex;
            longint ey;
            t_seg   seg;
            case (op)
                OP_SET_POSE: begin
                    pos_x   = longint'(nx);
                    pos_y   = longint'(ny);
                    heading = ang;
                end
                OP_FORWARD, OP_BACKWARD: begin
                    rotate_distance(longint'(move_len), heading, dx, dy);
                    if (op == OP_FORWARD) begin
                        ex = clamp32(pos_x + dx);
                        ey = clamp32(pos_y + dy);
                    end else begin
                        ex = clamp32(pos_x - dx);
                        ey = clamp32(pos_y - dy);
                    end
                    if (pen) begin
                        seg.sx = pos_x[31:0];
                        seg.sy = pos_y[31:0];
                        seg.ex = ex[31:0];
                        seg.ey = ey[31:0];
                        expected_segments.push_back(seg);
                    end
                    pos_x = ex;
                    pos_y = ey;
                end
                OP_RIGHT: heading = heading - ang;
                OP_LEFT:  heading = heading + ang;
                OP_PEN:   pen = pen_bit;
                OP_RESET: begin
                    pos_x   = 0;
                    pos_y   = 0;
                    heading = '0;
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] exp_v,
                                    logic [31:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name,
                         $signed(exp_v), $signed(act_v));
            end
        endfunction

        function void check_segment(logic [31:0] sx, logic [31:0] sy,
                                    logic [31:0] ex, logic [31:0] ey);
            t_seg seg;
            if (expected_segments.size() == 0) begin
                errors++;
                $display("%0t: segment expected none actual (%0d,%0d)-(%0d,%0d)",
                         $time, $signed(sx), $signed(sy), $signed(ex), $signed(ey));
            end else begin
                seg = expected_segments.pop_front();
                compare_field("start_x", seg.sx, sx);
                compare_field("start_y", seg.sy, sy);
                compare_field("end_x", seg.ex, ex);
                compare_field("end_y", seg.ey, ey);
            end
        endfunction

        function int pending();
            return expected_segments.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n      = 1'b0;
    logic               push         = 1'b0;
    logic               full;
    logic [2:0]         i_operation  = '0;
    logic signed [31:0] i_new_x      = '0;
    logic signed [31:0] i_new_y      = '0;
    logic [15:0]        i_angle      = '0;
    logic signed [31:0] i_distance   = '0;
    logic               i_pen_down   = 1'b0;
    logic               empty;
    logic               pop          = 1'b0;
    logic signed [31:0] o_start_x;
    logic signed [31:0] o_start_y;
    logic signed [31:0] o_end_x;
    logic signed [31:0] o_end_y;

    int             tx_idle_pct = 31;
    int             rx_idle_pct = 64;
    bit             hold_go     = 1'b0;
    int             cycle_count = 0;
    segment_tracker tracker;

    turtle_vector_generator_top #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_operation (i_operation),
        .i_new_x     (i_new_x),
        .i_new_y     (i_new_y),
        .i_angle     (i_angle),
        .i_distance  (i_distance),
        .i_pen_down  (i_pen_down),
        .empty       (empty),
        .pop         (pop),
        .o_start_x   (o_start_x),
        .o_start_y   (o_start_y),
        .o_end_x     (o_end_x),
        .o_end_y     (o_end_y)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Input and output monitors
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full)
            tracker.note_command(i_operation, i_new_x, i_new_y, i_angle,
                                 i_distance, i_pen_down);
        if (i_rst_n && pop && !empty)
            tracker.check_segment(o_start_x, o_start_y, o_end_x, o_end_y);
    end

    // Receiver: random pops, one long hold-off when requested
    int hold_left  = 0;
    bit hold_taken = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------
    task automatic send_cmd(input logic [2:0] op, input logic [31:0] nx,
                            input logic [31:0] ny, input logic [15:0] ang,
                            input logic [31:0] dist_val, input logic pen_bit);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_operation <= op;
        i_new_x     <= nx;
        i_new_y     <= ny;
        i_angle     <= ang;
        i_distance  <= dist_val;
        i_pen_down  <= pen_bit;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
    endtask

    // Sender stops until every predicted segment has been popped
    task automatic drain_segments();
        push <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_distance();
        int                 r;
        logic signed [31:0] v;
        r = $urandom_range(0, 99);
        v = $urandom();
        if (r < 60) begin
            // within +-16.0
            v = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        end else if (r < 85) begin
            v = v >>> $urandom_range(1, 16);
        end else if (r >= 95) begin
            case ($urandom_range(0, 4))
                0:       v = 32'sh7FFF_FFFF;
                1:       v = 32'sh8000_0000;
                2:       v = 32'sh0;
                3:       v = 32'sh1;
                default: v = -32'sh1;
            endcase
        end
        return v;
    endfunction

    function automatic logic [31:0] pick_coord();
        logic signed [31:0] v;
        v = $urandom();
        if ($urandom_range(0, 1) != 0)
            v = v >>> $urandom_range(4, 20);
        return v;
    endfunction

    task automatic send_random();
        int          r;
        logic [2:0]  op;
        logic        pen_bit;
        r       = $urandom_range(0, 99);
        pen_bit = 1'($urandom_range(0, 1));
        if (r < 25)       op = OP_FORWARD;
        else if (r < 40)  op = OP_BACKWARD;
        else if (r < 52)  op = OP_RIGHT;
        else if (r < 64)  op = OP_LEFT;
        else if (r < 78)  op = OP_PEN;
        else if (r < 88)  op = OP_SET_POSE;
        else if (r < 95)  op = OP_RESET;
        else              op = OP_UNUSED;
        // pen mostly down so moves draw
        if (op == OP_PEN)
            pen_bit = ($urandom_range(0, 3) != 0);
        send_cmd(op, pick_coord(), pick_coord(), 16'($urandom_range(0, 65535)),
                 pick_distance(), pen_bit);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        tracker = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corner cases
        send_cmd(OP_FORWARD,  '0, '0, 16'd0, 32'h0001_0000, 1'b0);  // pen up move
        send_cmd(OP_PEN,      '0, '0, 16'd0, '0, 1'b1);
        send_cmd(OP_FORWARD,  '0, '0, 16'd0, 32'h0001_0000, 1'b0);
        send_cmd(OP_LEFT,     '0, '0, 16'd16384, '0, 1'b0);
        send_cmd(OP_FORWARD,  '0, '0, 16'd0, 32'h7FFF_FFFF, 1'b0);
        send_cmd(OP_RIGHT,    '0, '0, 16'd1, '0, 1'b0);
        send_cmd(OP_BACKWARD, '0, '0, 16'd0, 32'h8000_0000, 1'b0);
        send_cmd(OP_SET_POSE, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0, '0, 1'b0);
        send_cmd(OP_FORWARD,  '0, '0, 16'd0, 32'h7FFF_FFFF, 1'b0);  // clamps high
        send_cmd(OP_SET_POSE, 32'h8000_0000, 32'h7FFF_FFFF, 16'd32768, '0, 1'b0);
        send_cmd(OP_FORWARD,  '0, '0, 16'd0, 32'h4000_0000, 1'b0);  // clamps low
        send_cmd(OP_SET_POSE, '0, '0, 16'd49152, '0, 1'b0);
        send_cmd(OP_FORWARD,  '0, '0, 16'd0, 32'h0003_0000, 1'b0);
        send_cmd(OP_SET_POSE, 32'h0010_0000, 32'hFFF0_0000, 16'd49151, '0, 1'b0);
        send_cmd(OP_BACKWARD, '0, '0, 16'd0, 32'hFFFF_FFFF, 1'b0);
        send_cmd(OP_RIGHT,    '0, '0, 16'd65535, '0, 1'b0);         // wraps
        send_cmd(OP_LEFT,     '0, '0, 16'd65535, '0, 1'b0);
        send_cmd(OP_RESET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                 32'hFFFF_FFFF, 1'b1);                               // pen kept
        send_cmd(OP_FORWARD,  '0, '0, 16'd0, 32'h0001_8000, 1'b0);
        send_cmd(OP_UNUSED,   32'h1234_5678, 32'h9ABC_DEF0, 16'hA5A5,
                 32'h7FFF_0000, 1'b1);                               // ignored
        send_cmd(OP_FORWARD,  '0, '0, 16'd0, 32'h0000_0001, 1'b0);
        send_cmd(OP_PEN,      '0, '0, 16'd0, '0, 1'b0);
        send_cmd(OP_BACKWARD, '0, '0, 16'd0, 32'h1234_5678, 1'b0);  // no segment
        send_cmd(OP_PEN,      '0, '0, 16'd0, '0, 1'b1);

        // Phase 1: sender idles less than receiver
        repeat (PHASE_ITEMS) send_random();
        drain_segments();

        // Phase 2: roles swapped
        tx_idle_pct = 64;
        rx_idle_pct = 31;
        repeat (PHASE_ITEMS) send_random();

        // Phase 3: no idling, receiver holds off long at the start
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_cmd(OP_PEN, '0, '0, 16'd0, '0, 1'b1);
        hold_go = 1'b1;
        repeat (PHASE_ITEMS) send_random();

        drain_segments();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/tvg_pkg.sv
src/tvg_fifo.sv
src/tvg_front.sv
src/tvg_back.sv
src/turtle_vector_generator_top.sv
dv/testbench.sv
